>>> hdl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the postfix stack calculator.
// ----------------------------------------------------------------------------
`default_nettype none
package rpn_pkg;
   localparam int STACK_DEPTH_DEF = 128;
   localparam int DATA_W = 32;
   localparam int CMD_W = 3;

   localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_MOD  = 3'd5;

   typedef struct packed {
      logic       start;
      logic [47:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

   function automatic logic [DATA_W-1:0] sat_mag(input logic neg, input logic [63:0] mag);
      logic [DATA_W-1:0] r;
      if (!neg) begin
         r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end else if (mag >= 64'h8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'(-mag[31:0]);
      end
      return r;
   endfunction
endpackage
`default_nettype wire

>>> hdl/rpn_divider.sv
// ----------------------------------------------------------------------------
// rpn_divider
// Restoring unsigned divider, 48-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rpn_pkg::div_req_type div_req,
   output rpn_pkg::div_rsp_type      div_rsp
);
   import rpn_pkg::*;

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[47]} - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;
endmodule
`default_nettype wire

>>> hdl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Postfix calculator on a memory-held Q16.16 value stack with saturation.
// ----------------------------------------------------------------------------
// Usage: drive req_cmd, req_operand, req_end_of_line and pulse start while
// busy is low; the word is taken at that edge and busy rises at once.
// Exactly one result word per request appears for one cycle with
// rsp_valid high; busy falls in that same cycle, so the next word can be
// taken there. Push and unknown commands go straight to S_PUSH; others
// pop b, then a, and compute in S_CALC; multiply adds S_MUL, divide and
// modulo wait in S_DIV on the bit-serial 48-step divider; then S_PUSH and
// S_DONE. End of line, not on push, adds S_SHOW, popping the top to show
// it. An empty pop flags the error and skips the read; a zero divisor is
// caught after b is popped, before a, and goes to S_PUSH. The stack lives
// in one synchronous RAM with a registered read port, so each pop is a
// read and wait. Reset clears the stack count and control state; RAM
// contents stay undefined and are never read below the count. The receiver
// cannot stall: each result word must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [rpn_pkg::CMD_W-1:0]  req_cmd,
   input  wire logic signed [31:0]         req_operand,
   input  wire logic                       req_end_of_line,
   output logic                            rsp_valid,
   output logic                            rsp_shown,
   output logic signed [31:0]              rsp_shown_value,
   output logic                            rsp_empty_error,
   output logic                            rsp_full_error,
   output logic                            rsp_zero_divide_error
);
   import rpn_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_POPB  = 9'b000000010,
      S_POPA  = 9'b000000100,
      S_CALC  = 9'b000001000,
      S_MUL   = 9'b000010000,
      S_DIV   = 9'b000100000,
      S_PUSH  = 9'b001000000,
      S_SHOW  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rd_data;
   logic        mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [31:0] mem_wd;

   state_type   st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic        eol_ff, eol_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic        bv_ff, bv_in, av_ff, av_in, sv_ff, sv_in;
   logic        ee_ff, ee_in, fe_ff, fe_in, zd_ff, zd_in, sh_ff, sh_in;
   logic        has_r_ff, has_r_in;
   logic [63:0] prod_ff, prod_in;
   logic        valid_ff, valid_in;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [31:0] ua, ub;
   logic signed [32:0] sum;

   rpn_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data <= mem[mem_ra];
   end

   always_comb begin
      ua = a_ff[31] ? 32'(-a_ff) : a_ff;
      ub = b_ff[31] ? 32'(-b_ff) : b_ff;
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; cmd_in = cmd_ff; eol_in = eol_ff;
      a_in = a_ff; b_in = b_ff; r_in = r_ff;
      bv_in = 1'b0; av_in = 1'b0; sv_in = 1'b0;
      ee_in = ee_ff; fe_in = fe_ff; zd_in = zd_ff; sh_in = sh_ff;
      has_r_in = has_r_ff; prod_in = prod_ff; valid_in = 1'b0;
      mem_we = 1'b0; mem_wa = cnt_ff[AW-1:0]; mem_wd = r_ff;
      mem_ra = AW'(cnt_ff - CW'(1));
      div_req = '0;
      sum = '0;
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_cmd; eol_in = req_end_of_line;
               ee_in = 1'b0; fe_in = 1'b0; zd_in = 1'b0; sh_in = 1'b0;
               r_in = req_operand; has_r_in = 1'b0;
               a_in = '0; b_in = '0;
               if (req_cmd == CMD_PUSH) begin
                  has_r_in = 1'b1; eol_in = 1'b0; st_in = S_PUSH;
               end else if (req_cmd == CMD_ADD || req_cmd == CMD_SUB ||
                            req_cmd == CMD_MUL || req_cmd == CMD_DIV ||
                            req_cmd == CMD_MOD) begin
                  st_in = S_POPB;
               end else begin
                  st_in = S_PUSH;
               end
            end
         end
         S_POPB: begin
            if (bv_ff) begin
               b_in = rd_data; st_in = S_POPA;
            end else if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CW'(1); bv_in = 1'b1;
            end else begin
               ee_in = 1'b1; b_in = '0; st_in = S_POPA;
            end
            if (!bv_ff && cnt_ff != '0) st_in = S_POPB;
         end
         S_POPA: begin
            if ((cmd_ff == CMD_DIV || cmd_ff == CMD_MOD) && b_ff == '0) begin
               zd_in = 1'b1; st_in = S_PUSH;
            end else if (av_ff) begin
               a_in = rd_data; st_in = S_CALC;
            end else if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CW'(1); av_in = 1'b1;
            end else begin
               ee_in = 1'b1; a_in = '0; st_in = S_CALC;
            end
         end
         S_CALC: begin
            has_r_in = 1'b1;
            case (cmd_ff)
               CMD_ADD: begin
                  sum = {a_ff[31], a_ff} + {b_ff[31], b_ff};
                  r_in = sat_mag(sum[32], sum[32] ? 64'(-sum) : 64'(sum));
                  st_in = S_PUSH;
               end
               CMD_SUB: begin
                  sum = {a_ff[31], a_ff} - {b_ff[31], b_ff};
                  r_in = sat_mag(sum[32], sum[32] ? 64'(-sum) : 64'(sum));
                  st_in = S_PUSH;
               end
               CMD_MUL: begin
                  prod_in = ua[31:0] * ub[31:0];
                  st_in = S_MUL;
               end
               default: begin
                  div_req.start = 1'b1;
                  div_req.dividend = (cmd_ff == CMD_MOD) ? {16'd0, ua[31:0]}
                                                         : {ua[31:0], 16'd0};
                  div_req.divisor = ub[31:0];
                  st_in = S_DIV;
               end
            endcase
         end
         S_MUL: begin
            r_in = sat_mag(a_ff[31] ^ b_ff[31], {16'd0, prod_ff[63:16]});
            st_in = S_PUSH;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (cmd_ff == CMD_MOD)
                  r_in = sat_mag(a_ff[31], {32'd0, div_rsp.remainder});
               else
                  r_in = sat_mag(a_ff[31] ^ b_ff[31], {16'd0, div_rsp.quotient});
               st_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (has_r_ff) begin
               if (cnt_ff < FULL) begin
                  mem_we = 1'b1; cnt_in = cnt_ff + CW'(1);
               end else begin
                  fe_in = 1'b1;
               end
            end
            has_r_in = 1'b0;
            st_in = eol_ff ? S_SHOW : S_DONE;
            if (eol_ff) sh_in = 1'b1;
            r_in = '0;
         end
         S_SHOW: begin
            if (sv_ff) begin
               r_in = rd_data; st_in = S_DONE;
            end else if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CW'(1); sv_in = 1'b1;
            end else begin
               ee_in = 1'b1; r_in = '0; st_in = S_DONE;
            end
         end
         S_DONE: begin
            valid_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_POPA && !av_ff) mem_ra = AW'(cnt_ff - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; valid_ff <= 1'b0;
         bv_ff <= 1'b0; av_ff <= 1'b0; sv_ff <= 1'b0; has_r_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; valid_ff <= valid_in;
         bv_ff <= bv_in; av_ff <= av_in; sv_ff <= sv_in; has_r_ff <= has_r_in;
      end
      cmd_ff <= cmd_in; eol_ff <= eol_in;
      a_ff <= a_in; b_ff <= b_in; r_ff <= r_in; prod_ff <= prod_in;
      ee_ff <= ee_in; fe_ff <= fe_in; zd_ff <= zd_in; sh_ff <= sh_in;
   end

   assign busy                  = (st_ff != S_IDLE);
   assign rsp_valid             = valid_ff;
   assign rsp_shown             = sh_ff;
   assign rsp_shown_value       = sh_ff ? r_ff : 32'sd0;
   assign rsp_empty_error       = ee_ff;
   assign rsp_full_error        = fe_ff;
   assign rsp_zero_divide_error = zd_ff;
endmodule
`default_nettype wire
